### rtl/tpsp_pkg.sv
// shared types, constants and the half-sine table for the three-phase sine pwm generator
package tpsp_pkg;

    localparam int HALF_WAVE_POINTS = 128;
    localparam int ADDR_W           = $clog2(HALF_WAVE_POINTS);
    localparam int POS_W            = ADDR_W + 1;
    localparam int AMP_FRAC         = 10;
    localparam int AMP_W            = 18;
    localparam int PSC_W            = 16;
    localparam int PSC_ACC_W        = PSC_W + AMP_FRAC;
    localparam int DUTY_W           = 8;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [AMP_W-1:0]  AMP_LIMIT = AMP_W'(254 << AMP_FRAC);
    localparam logic [AMP_W-1:0]  AMP_FULL  = AMP_W'(255 << AMP_FRAC);
    localparam logic [DUTY_W-1:0] MIDPOINT  = 8'd127;
    localparam logic [POS_W-1:0]  POS_A_INIT = 8'd0;
    localparam logic [POS_W-1:0]  B_OFFSET   = 8'd85;
    localparam logic [POS_W-1:0]  C_OFFSET   = 8'd43;

    // register reset values
    localparam logic [5:0]       PHASE_STEP_RST = 6'd1;
    localparam logic [9:0]       AMP_STEP_RST   = 10'd26;
    localparam logic [PSC_W-1:0] PSC_START_RST  = 16'd80;
    localparam logic [PSC_W-1:0] PSC_FLOOR_RST  = 16'd40;
    localparam logic [9:0]       PSC_STEP_RST   = 10'd10;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMP_STEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PSC_START  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PSC_FLOOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PSC_STEP   = 3'd4;

    // round(128 * sin(pi * i / 128))
    localparam logic [7:0] HALF_SINE_ROM [HALF_WAVE_POINTS] = '{
          0,   3,   6,   9,  13,  16,  19,  22,  25,  28,  31,  34,  37,  40,  43,  46,
         49,  52,  55,  58,  60,  63,  66,  68,  71,  74,  76,  79,  81,  84,  86,  88,
         91,  93,  95,  97,  99, 101, 103, 105, 106, 108, 110, 111, 113, 114, 116, 117,
        118, 119, 121, 122, 122, 123, 124, 125, 126, 126, 127, 127, 127, 128, 128, 128,
        128, 128, 128, 128, 127, 127, 127, 126, 126, 125, 124, 123, 122, 122, 121, 119,
        118, 117, 116, 114, 113, 111, 110, 108, 106, 105, 103, 101,  99,  97,  95,  93,
         91,  88,  86,  84,  81,  79,  76,  74,  71,  68,  66,  63,  60,  58,  55,  52,
         49,  46,  43,  40,  37,  34,  31,  28,  25,  22,  19,  16,  13,   9,   6,   3
    };

    // one phase as seen by the duty stage
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              upper;
    } phase_t;

    // contents of the stage between state update and duty computation
    typedef struct packed {
        logic [7:0]       amp;
        phase_t           ph_a;
        phase_t           ph_b;
        phase_t           ph_c;
        logic [PSC_W-1:0] prescale;
    } stage_t;

    // 127 +/- (amp * table) >> 8
    function automatic logic [DUTY_W-1:0] duty_of(input logic [7:0] amp,
                                                  input logic [7:0] tbl,
                                                  input logic       upper);
        logic [15:0]       prod;
        logic [DUTY_W-1:0] mag;
        prod = amp * tbl;
        mag  = prod[15:8];
        return upper ? (MIDPOINT + mag) : (MIDPOINT - mag);
    endfunction

endpackage

### rtl/three_phase_sine_pwm_generator.sv
// top level of the three-phase sine pwm generator
//
// usage:
//   input channel (in_valid / in_ready, field restart): each transfer is one tick.
//   restart = 0 advances the three phases, the amplitude ramp and the prescaler
//   ramp; restart = 1 reloads the initial positions, polarities, zero amplitude
//   and psc_start, and still produces one result from that reloaded state.
//   output channel (out_valid / out_ready): one result per input transfer with
//   duty_a, duty_b, duty_c (0..254) and timer_prescale.
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
//   write only while the block is idle. psc_start takes effect on reset/restart.
// pipeline: the state update is registered into the stage register at the
//   transfer edge, then table read / multiply go into the output register
//   when the stage moves on (out_valid low or out_ready high).
// throughput: one item per cycle unless the output stalls, set by the state update loop.
// reset: rst_n low clears both stage valids, loads the initial phase state and
//   the register reset values; no clearing pass, the table is constant.
// stall: while out_ready is low the output register holds; the middle stage
//   can still take one more item, after that in_ready drops.
module three_phase_sine_pwm_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tpsp_pkg::DUTY_W-1:0]         duty_a,
    output logic [tpsp_pkg::DUTY_W-1:0]         duty_b,
    output logic [tpsp_pkg::DUTY_W-1:0]         duty_c,
    output logic [tpsp_pkg::PSC_W-1:0]          timer_prescale,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tpsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int POS_W     = tpsp_pkg::POS_W;
    localparam int ADDR_W    = tpsp_pkg::ADDR_W;
    localparam int AMP_W     = tpsp_pkg::AMP_W;
    localparam int PSC_W     = tpsp_pkg::PSC_W;
    localparam int PSC_ACC_W = tpsp_pkg::PSC_ACC_W;
    localparam int AMP_FRAC  = tpsp_pkg::AMP_FRAC;
    localparam int DUTY_W    = tpsp_pkg::DUTY_W;

    // configuration registers
    logic [5:0]       phase_step_reg;
    logic [9:0]       amp_step_reg;
    logic [PSC_W-1:0] psc_start_reg;
    logic [PSC_W-1:0] psc_floor_reg;
    logic [9:0]       psc_step_reg;

    // generator state
    logic [POS_W-1:0]     pos_a_reg, pos_b_reg, pos_c_reg;
    logic [POS_W-1:0]     pos_a_next, pos_b_next, pos_c_next;
    logic                 half_a_reg, half_b_reg, half_c_reg;
    logic                 half_a_next, half_b_next, half_c_next;
    logic [AMP_W-1:0]     amp_acc_reg, amp_acc_next;
    logic [PSC_ACC_W-1:0] psc_acc_reg, psc_acc_next;

    // pipeline
    logic                 s1_valid_reg, s1_valid_next;
    tpsp_pkg::stage_t     s1_reg, s1_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]    duty_a_reg, duty_b_reg, duty_c_reg;
    logic [PSC_W-1:0]     prescale_reg;

    logic in_fire, out_take, s1_move, cfg_fire;

    // tick datapath
    logic [AMP_W-1:0]     amp_sum;
    logic [PSC_ACC_W-1:0] floor_q, step_q, psc_diff;
    logic [POS_W-1:0]     pos_a_w, pos_b_w, pos_c_w;
    logic                 half_a_w, half_b_w, half_c_w;
    logic [POS_W-1:0]     step_ext;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_take  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_take;
    assign in_ready  = !s1_valid_reg || out_take;
    assign in_fire   = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= tpsp_pkg::PHASE_STEP_RST;
            amp_step_reg   <= tpsp_pkg::AMP_STEP_RST;
            psc_start_reg  <= tpsp_pkg::PSC_START_RST;
            psc_floor_reg  <= tpsp_pkg::PSC_FLOOR_RST;
            psc_step_reg   <= tpsp_pkg::PSC_STEP_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                tpsp_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data[5:0];
                tpsp_pkg::CFG_AMP_STEP:   amp_step_reg   <= cfg_data[9:0];
                tpsp_pkg::CFG_PSC_START:  psc_start_reg  <= cfg_data;
                tpsp_pkg::CFG_PSC_FLOOR:  psc_floor_reg  <= cfg_data;
                tpsp_pkg::CFG_PSC_STEP:   psc_step_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tick: ramps, wraps, then position advance
    // ------------------------------------------------------------------
    assign step_ext = POS_W'(phase_step_reg);
    assign floor_q  = {psc_floor_reg, {AMP_FRAC{1'b0}}};
    assign step_q   = PSC_ACC_W'(psc_step_reg);
    assign psc_diff = psc_acc_reg - step_q;
    // cannot overflow: max 255.0 plus one step stays below 2^18
    assign amp_sum  = amp_acc_reg + AMP_W'(amp_step_reg);

    always_comb
    begin
        // phase A crossing the half wave drags B and C back into alignment
        pos_a_w  = pos_a_reg;
        pos_b_w  = pos_b_reg;
        pos_c_w  = pos_c_reg;
        half_a_w = half_a_reg;
        half_b_w = half_b_reg;
        half_c_w = half_c_reg;
        if (pos_a_reg[POS_W-1])
        begin
            pos_a_w  = {1'b0, pos_a_reg[ADDR_W-1:0]};
            half_a_w = !half_a_reg;
            half_b_w = !half_a_reg;
            half_c_w = half_a_reg;
            pos_b_w  = {1'b0, pos_a_reg[ADDR_W-1:0]} + tpsp_pkg::B_OFFSET;
            pos_c_w  = {1'b0, pos_a_reg[ADDR_W-1:0]} + tpsp_pkg::C_OFFSET;
        end
        else
        begin
            if (pos_b_reg[POS_W-1])
            begin
                pos_b_w  = {1'b0, pos_b_reg[ADDR_W-1:0]};
                half_b_w = !half_b_reg;
            end
            if (pos_c_reg[POS_W-1])
            begin
                pos_c_w  = {1'b0, pos_c_reg[ADDR_W-1:0]};
                half_c_w = !half_c_reg;
            end
        end
    end

    always_comb
    begin
        pos_a_next   = pos_a_reg;
        pos_b_next   = pos_b_reg;
        pos_c_next   = pos_c_reg;
        half_a_next  = half_a_reg;
        half_b_next  = half_b_reg;
        half_c_next  = half_c_reg;
        amp_acc_next = amp_acc_reg;
        psc_acc_next = psc_acc_reg;
        s1_next      = s1_reg;
        if (in_fire)
        begin
            if (restart)
            begin
                // initial state; result is built from it and the positions stay put
                pos_a_next   = tpsp_pkg::POS_A_INIT;
                pos_b_next   = tpsp_pkg::B_OFFSET;
                pos_c_next   = tpsp_pkg::C_OFFSET;
                half_a_next  = 1'b1;
                half_b_next  = 1'b1;
                half_c_next  = 1'b0;
                amp_acc_next = '0;
                psc_acc_next = {psc_start_reg, {AMP_FRAC{1'b0}}};
                s1_next.amp           = '0;
                s1_next.ph_a.addr     = tpsp_pkg::POS_A_INIT[ADDR_W-1:0];
                s1_next.ph_a.upper    = 1'b1;
                s1_next.ph_b.addr     = tpsp_pkg::B_OFFSET[ADDR_W-1:0];
                s1_next.ph_b.upper    = 1'b1;
                s1_next.ph_c.addr     = tpsp_pkg::C_OFFSET[ADDR_W-1:0];
                s1_next.ph_c.upper    = 1'b0;
                s1_next.prescale      = psc_start_reg;
            end
            else
            begin
                // amplitude ramp snaps to full scale past 254.0
                amp_acc_next = (amp_sum > tpsp_pkg::AMP_LIMIT) ? tpsp_pkg::AMP_FULL
                                                                : amp_sum;
                // prescaler ramp clamps at the floor, also on underflow
                if ((psc_acc_reg < step_q) || (psc_diff < floor_q))
                    psc_acc_next = floor_q;
                else
                    psc_acc_next = psc_diff;

                half_a_next = half_a_w;
                half_b_next = half_b_w;
                half_c_next = half_c_w;
                pos_a_next  = pos_a_w + step_ext;
                pos_b_next  = pos_b_w + step_ext;
                pos_c_next  = pos_c_w + step_ext;

                s1_next.amp        = amp_acc_next[AMP_W-1:AMP_FRAC];
                s1_next.ph_a.addr  = pos_a_w[ADDR_W-1:0];
                s1_next.ph_a.upper = half_a_w;
                s1_next.ph_b.addr  = pos_b_w[ADDR_W-1:0];
                s1_next.ph_b.upper = half_b_w;
                s1_next.ph_c.addr  = pos_c_w[ADDR_W-1:0];
                s1_next.ph_c.upper = half_c_w;
                s1_next.prescale   = psc_acc_next[PSC_ACC_W-1:AMP_FRAC];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_a_reg     <= tpsp_pkg::POS_A_INIT;
            pos_b_reg     <= tpsp_pkg::B_OFFSET;
            pos_c_reg     <= tpsp_pkg::C_OFFSET;
            half_a_reg    <= 1'b1;
            half_b_reg    <= 1'b1;
            half_c_reg    <= 1'b0;
            amp_acc_reg   <= '0;
            psc_acc_reg   <= {tpsp_pkg::PSC_START_RST, {AMP_FRAC{1'b0}}};
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_a_reg     <= pos_a_next;
            pos_b_reg     <= pos_b_next;
            pos_c_reg     <= pos_c_next;
            half_a_reg    <= half_a_next;
            half_b_reg    <= half_b_next;
            half_c_reg    <= half_c_next;
            amp_acc_reg   <= amp_acc_next;
            psc_acc_reg   <= psc_acc_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage payload and duty stage: table read, multiply, offset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (s1_move)
        begin
            duty_a_reg   <= tpsp_pkg::duty_of(s1_reg.amp,
                                tpsp_pkg::HALF_SINE_ROM[s1_reg.ph_a.addr], s1_reg.ph_a.upper);
            duty_b_reg   <= tpsp_pkg::duty_of(s1_reg.amp,
                                tpsp_pkg::HALF_SINE_ROM[s1_reg.ph_b.addr], s1_reg.ph_b.upper);
            duty_c_reg   <= tpsp_pkg::duty_of(s1_reg.amp,
                                tpsp_pkg::HALF_SINE_ROM[s1_reg.ph_c.addr], s1_reg.ph_c.upper);
            prescale_reg <= s1_reg.prescale;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duty_a         = duty_a_reg;
    assign duty_b         = duty_b_reg;
    assign duty_c         = duty_c_reg;
    assign timer_prescale = prescale_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // amplitude never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        amp_acc_reg <= tpsp_pkg::AMP_FULL)
        else $error("amplitude accumulator above full scale");

    // a restart transfer always carries zero amplitude into the duty stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart) |=> (s1_valid_reg && s1_reg.amp == '0))
        else $error("restart did not clear the staged amplitude");

    // a tick leaves the prescaler at or above the floor
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !restart && !cfg_fire)
            |=> (psc_acc_reg >= {psc_floor_reg, {AMP_FRAC{1'b0}}}))
        else $error("prescaler below floor after a tick");

    // duties stay inside 0..254
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (duty_a_reg != 8'hFF && duty_b_reg != 8'hFF
                           && duty_c_reg != 8'hFF))
        else $error("duty out of range");

endmodule
